// ----- sv/white_box_sm4_table_encrypt_defines.svh -----
// Assertion macros shared by the white-box SM4 RTL.
`ifndef WHITE_BOX_SM4_TABLE_ENCRYPT_DEFINES_SVH
`define WHITE_BOX_SM4_TABLE_ENCRYPT_DEFINES_SVH

`ifndef ASSERT_OFF
`define WBS4_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("wbs4 assertion failed");
`define WBS4_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("wbs4 assertion failed");
`define WBS4_ASSERT_ALW(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("wbs4 assertion failed");
`else
`define WBS4_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WBS4_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define WBS4_ASSERT_ALW(lbl, clk, rst_n, expr)
`endif

`endif

// ----- sv/wbs4_pkg.sv -----
// Types, codes, constants and the S-box for the white-box SM4 block.
package wbs4_pkg;

	localparam int ROUNDS      = 32;
	localparam int ROUND_W     = $clog2(ROUNDS);
	localparam int LANES       = 4;
	localparam int MIX_TABLES  = 3;
	localparam int ENC_WORDS   = 4;
	localparam int ENTRY_DEPTH = 256;
	localparam int RND_DEPTH   = ROUNDS * ENTRY_DEPTH;

	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_ENCRYPT = 1'b1;

	localparam logic [2:0] KIND_MIX0    = 3'd0;
	localparam logic [2:0] KIND_OLD     = 3'd3;
	localparam logic [2:0] KIND_SBO     = 3'd4;
	localparam logic [2:0] KIND_IN_ENC  = 3'd5;
	localparam logic [2:0] KIND_OUT_ENC = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENC_IN,
		ST_FIRST,
		ST_SUB,
		ST_MIX,
		ST_OUT,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		XS_HOLD,
		XS_BLOCK,
		XS_ENC,
		XS_SHIFT
	} x_sel_t;

	typedef struct packed {
		logic   wr;
		x_sel_t x_sel;
		logic   round_clr;
		logic   round_inc;
		logic   in_rd;
		logic   mix_rd;
		logic   sub_rd;
		logic   out_rd;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic last_round;
	} dp_sts_t;

	localparam logic [7:0] SBOX [ENTRY_DEPTH] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] lane);
		return w[8 * (3 - int'(lane)) +: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

// ----- sv/wbs4_ram.sv -----
// Simple dual-port RAM with registered read for the lookup tables.
module wbs4_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/wbs4_ctrl.sv -----
// Sequencer for table writes and the encryption passes.
`include "white_box_sm4_table_encrypt_defines.svh"
module wbs4_ctrl import wbs4_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    command,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_ENCRYPT) begin
					state_d = ST_ENC_IN;
				end
			end
			ST_ENC_IN: state_d = ST_FIRST;
			ST_FIRST:  state_d = ST_SUB;
			ST_SUB:    state_d = sts.last_round ? ST_OUT : ST_MIX;
			ST_MIX:    state_d = ST_SUB;
			ST_OUT:    state_d = ST_FIN;
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.x_sel = XS_HOLD;
		case (state_q)
			ST_IDLE: begin
				cmd.wr = accept && command == CMD_WRITE;
				if (accept && command == CMD_ENCRYPT) begin
					cmd.x_sel     = XS_BLOCK;
					cmd.round_clr = 1'b1;
				end
			end
			ST_ENC_IN: cmd.in_rd = 1'b1;
			ST_FIRST: begin
				cmd.x_sel  = XS_ENC;
				cmd.mix_rd = 1'b1;
			end
			ST_SUB: begin
				cmd.sub_rd    = 1'b1;
				cmd.round_inc = 1'b1;
			end
			ST_MIX: begin
				cmd.x_sel  = XS_SHIFT;
				cmd.mix_rd = 1'b1;
			end
			ST_OUT: begin
				cmd.x_sel  = XS_SHIFT;
				cmd.out_rd = 1'b1;
			end
			ST_FIN:  cmd.out_load = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`WBS4_ASSERT_ALW(a_one_read_group, clk, arst_n,
		$onehot0({cmd.in_rd, cmd.mix_rd, cmd.sub_rd, cmd.out_rd}))
	`WBS4_ASSERT_NXT(a_fin_holds, clk, arst_n,
		state_q == ST_FIN && out_valid_q && !out_ready, state_q == ST_FIN)
	`WBS4_ASSERT_NXT(a_last_round_exits, clk, arst_n,
		state_q == ST_SUB && sts.last_round, state_q == ST_OUT)
	`WBS4_ASSERT_NXT(a_encrypt_starts, clk, arst_n,
		accept && command == CMD_ENCRYPT, state_q == ST_ENC_IN)
	`WBS4_ASSERT_IMP(a_load_needs_slot, clk, arst_n,
		cmd.out_load, slot_free && state_q == ST_FIN)

endmodule

// ----- sv/wbs4_dp.sv -----
// Table memories, word registers and lookup datapath of the white-box SM4 block.
module wbs4_dp import wbs4_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  dp_cmd_t      cmd,
	output dp_sts_t      sts,
	input  logic [2:0]   table_kind,
	input  logic [4:0]   table_round,
	input  logic [1:0]   byte_position,
	input  logic [7:0]   table_entry,
	input  logic [31:0]  table_word,
	input  logic [63:0]  block_hi,
	input  logic [63:0]  block_lo,
	output logic [63:0]  cipher_hi,
	output logic [63:0]  cipher_lo
);

	localparam int RAW = $clog2(RND_DEPTH);

	logic [ROUND_W-1:0] round_q;
	logic [31:0]        x_q [ENC_WORDS];
	logic [31:0]        x_n [ENC_WORDS];
	logic [31:0]        x4;
	logic [31:0]        mix_sum;
	logic [31:0]        sub_val;
	logic [63:0]        cipher_hi_q;
	logic [63:0]        cipher_lo_q;
	logic [RAW-1:0]     wr_rnd_addr;
	logic [31:0]        mix_rd [MIX_TABLES][LANES];
	logic [31:0]        old_rd [LANES];
	logic [31:0]        sbo_rd [LANES];
	logic [31:0]        in_rd  [ENC_WORDS][LANES];
	logic [31:0]        out_rd [ENC_WORDS][LANES];
	logic [31:0]        in_sum [ENC_WORDS];
	logic [31:0]        out_sum [ENC_WORDS];

	assign wr_rnd_addr    = {table_round, table_entry};
	assign sts.last_round = (round_q == ROUND_W'(ROUNDS - 1));

	for (genvar k = 0; k < MIX_TABLES; k++) begin : g_mix
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic           we;
			logic [RAW-1:0] raddr;
			assign we    = cmd.wr && table_kind == 3'(int'(KIND_MIX0) + k)
				&& byte_position == 2'(l);
			assign raddr = {round_q, byte_of(x_n[k + 1], 2'(l))};
			wbs4_ram #(.DEPTH(RND_DEPTH), .WIDTH(32)) u_ram (
				.clk   (clk),
				.we    (we),
				.waddr (wr_rnd_addr),
				.wdata (table_word),
				.re    (cmd.mix_rd),
				.raddr (raddr),
				.rdata (mix_rd[k][l])
			);
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_rnd
		logic           old_we;
		logic           sbo_we;
		logic [RAW-1:0] old_addr;
		logic [RAW-1:0] sbo_addr;
		assign old_we   = cmd.wr && table_kind == KIND_OLD && byte_position == 2'(l);
		assign sbo_we   = cmd.wr && table_kind == KIND_SBO && byte_position == 2'(l);
		assign old_addr = {round_q, byte_of(x_q[0], 2'(l))};
		assign sbo_addr = {round_q, byte_of(sub_val, 2'(l))};
		wbs4_ram #(.DEPTH(RND_DEPTH), .WIDTH(32)) u_old (
			.clk   (clk),
			.we    (old_we),
			.waddr (wr_rnd_addr),
			.wdata (table_word),
			.re    (cmd.sub_rd),
			.raddr (old_addr),
			.rdata (old_rd[l])
		);
		wbs4_ram #(.DEPTH(RND_DEPTH), .WIDTH(32)) u_sbo (
			.clk   (clk),
			.we    (sbo_we),
			.waddr (wr_rnd_addr),
			.wdata (table_word),
			.re    (cmd.sub_rd),
			.raddr (sbo_addr),
			.rdata (sbo_rd[l])
		);
	end

	for (genvar w = 0; w < ENC_WORDS; w++) begin : g_enc
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic in_we;
			logic out_we;
			logic sel;
			assign sel    = cmd.wr && table_round == ROUND_W'(w) && byte_position == 2'(l);
			assign in_we  = sel && table_kind == KIND_IN_ENC;
			assign out_we = sel && table_kind == KIND_OUT_ENC;
			wbs4_ram #(.DEPTH(ENTRY_DEPTH), .WIDTH(32)) u_in (
				.clk   (clk),
				.we    (in_we),
				.waddr (table_entry),
				.wdata (table_word),
				.re    (cmd.in_rd),
				.raddr (byte_of(x_q[w], 2'(l))),
				.rdata (in_rd[w][l])
			);
			wbs4_ram #(.DEPTH(ENTRY_DEPTH), .WIDTH(32)) u_out (
				.clk   (clk),
				.we    (out_we),
				.waddr (table_entry),
				.wdata (table_word),
				.re    (cmd.out_rd),
				.raddr (byte_of(x_n[ENC_WORDS - 1 - w], 2'(l))),
				.rdata (out_rd[w][l])
			);
		end
	end

	always_comb begin
		x4      = '0;
		mix_sum = '0;
		for (int l = 0; l < LANES; l++) begin
			x4 = x4 ^ old_rd[l] ^ sbo_rd[l];
			for (int k = 0; k < MIX_TABLES; k++) begin
				mix_sum = mix_sum ^ mix_rd[k][l];
			end
		end
		for (int w = 0; w < ENC_WORDS; w++) begin
			in_sum[w]  = '0;
			out_sum[w] = '0;
			for (int l = 0; l < LANES; l++) begin
				in_sum[w]  = in_sum[w] ^ in_rd[w][l];
				out_sum[w] = out_sum[w] ^ out_rd[w][l];
			end
		end
	end

	assign sub_val = sub_word(mix_sum);

	always_comb begin
		x_n = x_q;
		case (cmd.x_sel)
			XS_BLOCK: begin
				x_n[0] = block_hi[63:32];
				x_n[1] = block_hi[31:0];
				x_n[2] = block_lo[63:32];
				x_n[3] = block_lo[31:0];
			end
			XS_ENC:   x_n = in_sum;
			XS_SHIFT: begin
				x_n[0] = x_q[1];
				x_n[1] = x_q[2];
				x_n[2] = x_q[3];
				x_n[3] = x4;
			end
			default:  x_n = x_q;
		endcase
	end

	always_ff @(posedge clk) begin
		x_q <= x_n;
		if (cmd.out_load) begin
			cipher_hi_q <= {out_sum[0], out_sum[1]};
			cipher_lo_q <= {out_sum[2], out_sum[3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.round_clr) begin
			round_q <= '0;
		end else if (cmd.round_inc) begin
			round_q <= round_q + ROUND_W'(1);
		end
	end

	assign cipher_hi = cipher_hi_q;
	assign cipher_lo = cipher_lo_q;

endmodule

// ----- sv/white_box_sm4_table_encrypt.sv -----
// Table-driven white-box SM4 encryption: top level joining sequencer and datapath.
// A table-write request is written in the cycle it is accepted and yields no result.
// An encryption request passes these steps from acceptance to a valid result: the
// input-encoding lookups; applying the input encoding and reading the first round's
// mixing tables; the 32 rounds (old-word and S-box-output lookups in every round, and
// between rounds a word shift with the next round's mixing lookups, each through a
// registered-read table memory); the last shift and the output-encoding lookups; and
// loading the result. The next request is taken only once the sequencer is idle again,
// after the result is loaded. The tables have no reset and no clearing pass: every entry
// an encryption reads must be written first. A finished result waits in an output
// register, so new requests are taken while it is pending; a later result holds in its
// load cycle until the earlier one is taken.
module white_box_sm4_table_encrypt import wbs4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [2:0]  table_kind,
	input  logic [4:0]  table_round,
	input  logic [1:0]  byte_position,
	input  logic [7:0]  table_entry,
	input  logic [31:0] table_word,
	input  logic [63:0] block_hi,
	input  logic [63:0] block_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_hi,
	output logic [63:0] cipher_lo
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	wbs4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	wbs4_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.table_kind    (table_kind),
		.table_round   (table_round),
		.byte_position (byte_position),
		.table_entry   (table_entry),
		.table_word    (table_word),
		.block_hi      (block_hi),
		.block_lo      (block_lo),
		.cipher_hi     (cipher_hi),
		.cipher_lo     (cipher_lo)
	);

endmodule

// ----- sim/tb_white_box_sm4_table_encrypt.sv -----
// Testbench for the white-box SM4 block: fills the tables, then checks encryptions.
`timescale 1ns / 100ps

module tb_white_box_sm4_table_encrypt;
	import wbs4_pkg::*;

	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS = 125;
	localparam int SET_BYTES = 8;

	localparam logic [7:0] SUBST_BYTES [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic        cmd;
		logic [2:0]  kind;
		logic [4:0]  rnd;
		logic [1:0]  lane;
		logic [7:0]  entry;
		logic [31:0] word;
		logic [63:0] hi;
		logic [63:0] lo;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [2:0]  table_kind = '0;
	logic [4:0]  table_round = '0;
	logic [1:0]  byte_position = '0;
	logic [7:0]  table_entry = '0;
	logic [31:0] table_word = '0;
	logic [63:0] block_hi = '0;
	logic [63:0] block_lo = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] cipher_hi;
	logic [63:0] cipher_lo;

	bit [31:0] mix_tbl [ROUNDS * MIX_TABLES][LANES][ENTRY_DEPTH];
	bit [31:0] old_tbl [ROUNDS][LANES][ENTRY_DEPTH];
	bit [31:0] sbo_tbl [ROUNDS][LANES][ENTRY_DEPTH];
	bit [31:0] in_enc_tbl [ENC_WORDS][LANES][ENTRY_DEPTH];
	bit [31:0] out_enc_tbl [ENC_WORDS][LANES][ENTRY_DEPTH];

	// Inner values keep each byte lane in {0, lane_span}; plaintext bytes come from plain_bytes.
	logic [7:0] lane_span [LANES];
	logic [7:0] plain_bytes [ENC_WORDS][LANES][SET_BYTES];

	request_t     request_q [$];
	logic [127:0] cipher_q [$];
	request_t     next_req;
	logic [127:0] want_cipher;
	idle_mode_t   idle_mode = IDLE_NONE;
	int           mismatches = 0;
	int           idle_cycles = 0;

	white_box_sm4_table_encrypt DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.table_kind    (table_kind),
		.table_round   (table_round),
		.byte_position (byte_position),
		.table_entry   (table_entry),
		.table_word    (table_word),
		.block_hi      (block_hi),
		.block_lo      (block_lo),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cipher_hi     (cipher_hi),
		.cipher_lo     (cipher_lo)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] table_xor(logic [2:0] kind, int idx, logic [31:0] w);
		logic [31:0] acc;
		logic [7:0]  b;
		acc = '0;
		for (int l = 0; l < LANES; l++) begin
			b = w[8 * (3 - l) +: 8];
			case (kind)
				KIND_MIX0:    acc ^= mix_tbl[idx][l][b];
				KIND_OLD:     acc ^= old_tbl[idx][l][b];
				KIND_SBO:     acc ^= sbo_tbl[idx][l][b];
				KIND_IN_ENC:  acc ^= in_enc_tbl[idx][l][b];
				default:      acc ^= out_enc_tbl[idx][l][b];
			endcase
		end
		return acc;
	endfunction

	function automatic logic [31:0] sbox_word(logic [31:0] w);
		return {SUBST_BYTES[w[31:24]], SUBST_BYTES[w[23:16]], SUBST_BYTES[w[15:8]],
			SUBST_BYTES[w[7:0]]};
	endfunction

	function automatic logic [127:0] cipher_of(logic [63:0] hi, logic [63:0] lo);
		logic [31:0] x [4];
		logic [31:0] f;
		x[0] = table_xor(KIND_IN_ENC, 0, hi[63:32]);
		x[1] = table_xor(KIND_IN_ENC, 1, hi[31:0]);
		x[2] = table_xor(KIND_IN_ENC, 2, lo[63:32]);
		x[3] = table_xor(KIND_IN_ENC, 3, lo[31:0]);
		for (int r = 0; r < ROUNDS; r++) begin
			f = table_xor(KIND_MIX0, r * 3, x[1]) ^ table_xor(KIND_MIX0, r * 3 + 1, x[2])
				^ table_xor(KIND_MIX0, r * 3 + 2, x[3]);
			f = table_xor(KIND_OLD, r, x[0]) ^ table_xor(KIND_SBO, r, sbox_word(f));
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = f;
		end
		return {table_xor(KIND_OUT_ENC, 0, x[3]), table_xor(KIND_OUT_ENC, 1, x[2]),
			table_xor(KIND_OUT_ENC, 2, x[1]), table_xor(KIND_OUT_ENC, 3, x[0])};
	endfunction

	function automatic void store_table_word(request_t q);
		if (q.kind <= 3'd2) begin
			mix_tbl[int'(q.rnd) * 3 + int'(q.kind)][q.lane][q.entry] = q.word;
		end else if (q.kind == KIND_OLD) begin
			old_tbl[q.rnd][q.lane][q.entry] = q.word;
		end else if (q.kind == KIND_SBO) begin
			sbo_tbl[q.rnd][q.lane][q.entry] = q.word;
		end else if (q.kind == KIND_IN_ENC && q.rnd < ENC_WORDS) begin
			in_enc_tbl[q.rnd][q.lane][q.entry] = q.word;
		end else if (q.kind == KIND_OUT_ENC && q.rnd < ENC_WORDS) begin
			out_enc_tbl[q.rnd][q.lane][q.entry] = q.word;
		end
	endfunction

	function automatic request_t random_request();
		request_t q;
		q.cmd   = 1'($urandom);
		q.kind  = 3'($urandom);
		q.rnd   = 5'($urandom);
		q.lane  = 2'($urandom);
		q.entry = 8'($urandom);
		q.word  = $urandom;
		q.hi    = {$urandom, $urandom};
		q.lo    = {$urandom, $urandom};
		return q;
	endfunction

	function automatic void push_write(logic [2:0] kind, int rnd, int lane, logic [7:0] entry,
			logic [31:0] word);
		request_t q;
		q       = random_request();
		q.cmd   = CMD_WRITE;
		q.kind  = kind;
		q.rnd   = 5'(rnd);
		q.lane  = 2'(lane);
		q.entry = entry;
		q.word  = word;
		request_q.push_back(q);
	endfunction

	function automatic void push_encrypt(logic [127:0] blk);
		request_t q;
		q     = random_request();
		q.cmd = CMD_ENCRYPT;
		q.hi  = blk[127:64];
		q.lo  = blk[63:0];
		request_q.push_back(q);
	endfunction

	function automatic logic [31:0] span_word();
		logic [31:0] w;
		for (int l = 0; l < LANES; l++)
			w[8 * (3 - l) +: 8] = $urandom_range(0, 1) ? lane_span[l] : 8'h00;
		return w;
	endfunction

	function automatic logic [7:0] span_byte(int lane);
		return $urandom_range(0, 1) ? lane_span[lane] : 8'h00;
	endfunction

	function automatic logic [127:0] random_block();
		logic [127:0] blk;
		for (int w = 0; w < ENC_WORDS; w++)
			for (int l = 0; l < LANES; l++)
				blk[127 - 32 * w - 8 * l -: 8] = plain_bytes[w][l][$urandom_range(0, SET_BYTES - 1)];
		return blk;
	endfunction

	function automatic void fill_tables();
		for (int r = 0; r < ROUNDS; r++)
			for (int l = 0; l < LANES; l++)
				for (int v = 0; v < 2; v++) begin
					for (int t = 0; t < MIX_TABLES; t++)
						push_write(3'(KIND_MIX0 + t), r, l, v ? lane_span[l] : 8'h00, span_word());
					push_write(KIND_OLD, r, l, v ? lane_span[l] : 8'h00, span_word());
					push_write(KIND_SBO, r, l, SUBST_BYTES[v ? lane_span[l] : 8'h00], span_word());
				end
		for (int w = 0; w < ENC_WORDS; w++)
			for (int l = 0; l < LANES; l++) begin
				for (int s = 0; s < SET_BYTES; s++)
					push_write(KIND_IN_ENC, w, l, plain_bytes[w][l][s], span_word());
				push_write(KIND_OUT_ENC, w, l, 8'h00, $urandom);
				push_write(KIND_OUT_ENC, w, l, lane_span[l], $urandom);
			end
	endfunction

	function automatic void random_overwrite();
		int l;
		int w;
		l = $urandom_range(0, 3);
		w = $urandom_range(0, ENC_WORDS - 1);
		case ($urandom_range(0, 4))
			0: push_write(3'(KIND_MIX0 + $urandom_range(0, 2)), $urandom_range(0, 31), l,
				span_byte(l), span_word());
			1: push_write(KIND_OLD, $urandom_range(0, 31), l, span_byte(l), span_word());
			2: push_write(KIND_SBO, $urandom_range(0, 31), l, SUBST_BYTES[span_byte(l)],
				span_word());
			3: push_write(KIND_IN_ENC, w, l, plain_bytes[w][l][$urandom_range(0, SET_BYTES - 1)],
				span_word());
			default: push_write(KIND_OUT_ENC, w, l, span_byte(l), $urandom);
		endcase
	endfunction

	function automatic void push_noise();
		request_t q;
		q     = random_request();
		q.cmd = CMD_WRITE;
		if ($urandom_range(0, 1)) begin
			q.kind = KIND_UNUSED;
		end else begin
			q.kind = $urandom_range(0, 1) ? KIND_IN_ENC : KIND_OUT_ENC;
			q.rnd  = 5'($urandom_range(ENC_WORDS, 31));
		end
		request_q.push_back(q);
	endfunction

	function automatic void push_directed();
		request_t q;
		q      = random_request();
		q.cmd  = CMD_WRITE;
		q.kind = KIND_UNUSED;
		q.hi   = '1;
		q.lo   = '1;
		request_q.push_back(q);
		push_write(KIND_IN_ENC, 4, 0, 8'h00, 32'hffffffff);
		push_write(KIND_OUT_ENC, 31, 3, 8'hff, 32'hffffffff);
		push_write(KIND_IN_ENC, 31, 3, 8'hff, 32'hffffffff);
		push_write(KIND_OUT_ENC, 0, 0, 8'h00, 32'hffffffff);
		push_write(KIND_OUT_ENC, 3, 3, lane_span[3], 32'h0);
		push_write(3'(KIND_MIX0 + 2), 31, 3, lane_span[3], span_word());
		push_write(KIND_MIX0, 0, 0, 8'h00, 32'h0);
		push_encrypt('0);
		push_encrypt('1);
		push_write(KIND_OLD, 31, 3, 8'h00, span_word());
		push_write(KIND_SBO, 0, 0, SUBST_BYTES[lane_span[0]], span_word());
		push_encrypt(random_block());
		push_write(KIND_IN_ENC, 3, 3, 8'hff, span_word());
		push_write(KIND_IN_ENC, 0, 0, 8'h00, 32'h0);
		push_encrypt('1);
		push_encrypt(random_block());
	endfunction

	function automatic int send_gap_pct();
		return idle_mode == IDLE_SENDER ? 51 : idle_mode == IDLE_BOTH ? 26 : 0;
	endfunction

	function automatic int stall_pct();
		return idle_mode == IDLE_RECEIVER ? 51 : idle_mode == IDLE_BOTH ? 26 : 0;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (command == CMD_WRITE) begin
					next_req.cmd   = command;
					next_req.kind  = table_kind;
					next_req.rnd   = table_round;
					next_req.lane  = byte_position;
					next_req.entry = table_entry;
					next_req.word  = table_word;
					store_table_word(next_req);
				end else begin
					cipher_q.push_back(cipher_of(block_hi, block_lo));
				end
			end
			if (!in_valid || in_ready) begin
				if (request_q.size() != 0 && $urandom_range(1, 100) > send_gap_pct()) begin
					next_req = request_q.pop_front();
					in_valid      <= 1'b1;
					command       <= next_req.cmd;
					table_kind    <= next_req.kind;
					table_round   <= next_req.rnd;
					byte_position <= next_req.lane;
					table_entry   <= next_req.entry;
					table_word    <= next_req.word;
					block_hi      <= next_req.hi;
					block_lo      <= next_req.lo;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					report_mismatch("unexpected cipher_hi", cipher_hi, 'x);
				end else begin
					want_cipher = cipher_q.pop_front();
					if (cipher_hi !== want_cipher[127:64])
						report_mismatch("cipher_hi", cipher_hi, want_cipher[127:64]);
					if (cipher_lo !== want_cipher[63:0])
						report_mismatch("cipher_lo", cipher_lo, want_cipher[63:0]);
				end
			end
			out_ready <= ($urandom_range(1, 100) > stall_pct());
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		for (int l = 0; l < LANES; l++)
			lane_span[l] = 8'($urandom_range(1, 255));
		for (int w = 0; w < ENC_WORDS; w++)
			for (int l = 0; l < LANES; l++) begin
				plain_bytes[w][l][0] = 8'h00;
				plain_bytes[w][l][1] = 8'hff;
				for (int s = 2; s < SET_BYTES; s++)
					plain_bytes[w][l][s] = 8'($urandom);
			end
		fill_tables();
		push_directed();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
			idle_mode = idle_mode_t'(m);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(1, 100);
				if (pick <= 45)
					push_encrypt(random_block());
				else if (pick <= 90)
					random_overwrite();
				else
					push_noise();
			end
			while (request_q.size() != 0 || in_valid)
				@(posedge clk);
		end
		while (cipher_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
